### rtl/hsk_pkg.sv
// ----------------------------------------------------------------------------
// hsk_pkg: shared types and constants for the HMAC-SHA256 keystream unit
// Holds the SHA-256 round constants, initial hash words, register indexes and
// the command/status structures between controller and datapath.
// ----------------------------------------------------------------------------
package hsk_pkg;

  localparam int unsigned NumRegs  = 6;
  localparam int unsigned RegIdxW  = 3;

  localparam logic [RegIdxW-1:0] RegKey0   = 3'd0;
  localparam logic [RegIdxW-1:0] RegKey1   = 3'd1;
  localparam logic [RegIdxW-1:0] RegKey2   = 3'd2;
  localparam logic [RegIdxW-1:0] RegKey3   = 3'd3;
  localparam logic [RegIdxW-1:0] RegNonceH = 3'd4;
  localparam logic [RegIdxW-1:0] RegNonceL = 3'd5;

  localparam logic [31:0] Ipad = 32'h3636_3636;
  localparam logic [31:0] Opad = 32'h5c5c_5c5c;
  localparam logic [31:0] PadWord = 32'h8000_0000;
  localparam logic [31:0] InnerBits = 32'd704;
  localparam logic [31:0] OuterBits = 32'd768;

  // Which 16-word block the schedule is loaded with.
  typedef enum logic [1:0] {
    LdKeyIpad  = 2'd0,
    LdNonce    = 2'd1,
    LdKeyOpad  = 2'd2,
    LdInner    = 2'd3
  } load_sel_e;

  typedef struct packed {
    logic      load;      // load schedule, and hash state from IV if init set
    logic      init;      // hash state takes the initial hash words
    load_sel_e sel;
    logic      start;     // copy hash state into working variables
    logic      round;     // perform one round
    logic      fold;      // add working variables into hash state
    logic      save_inner;
    logic      save_ks;   // keystream block takes the hash state
  } dp_cmd_t;

  typedef struct packed {
    logic last_round;     // round 63 is being performed
  } dp_sts_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

endpackage

### rtl/hsk_datapath.sv
// ----------------------------------------------------------------------------
// hsk_datapath: SHA-256 round engine with HMAC block loading
// One compression round per cycle over a 16-word rolling schedule; holds the
// key and nonce registers, hash state, inner digest and keystream block.
// ----------------------------------------------------------------------------
module hsk_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [hsk_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [63:0]              cfg_data_i,
  input  logic [63:0]              ctr_i,
  input  hsk_pkg::dp_cmd_t         cmd_i,
  output hsk_pkg::dp_sts_t         sts_o,
  input  logic [4:0]               off_i,
  output logic [7:0]               ks_byte_o
);
  import hsk_pkg::*;

  logic [63:0] regs_q [NumRegs];
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [31:0] inner_q [8];
  logic [255:0] ks_q;
  logic [5:0]  t_q;

  logic [31:0] blk [16];
  logic [31:0] wt, wnew, s0, s1, t1, t2, e, a, ctr_lo, ctr_hi;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) regs_q[i] <= '0;
    end else if (cfg_we_i && (cfg_idx_i <= RegNonceL)) begin
      regs_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign ctr_lo = swap32(ctr_i[31:0]);
  assign ctr_hi = swap32(ctr_i[63:32]);

  always_comb begin
    for (int i = 0; i < 16; i++) blk[i] = '0;
    unique case (cmd_i.sel) inside
      LdKeyIpad, LdKeyOpad: begin
        for (int i = 0; i < 16; i++) begin
          blk[i] = (cmd_i.sel == LdKeyIpad) ? Ipad : Opad;
        end
        for (int i = 0; i < 4; i++) begin
          blk[2*i]   = blk[2*i]   ^ regs_q[i][63:32];
          blk[2*i+1] = blk[2*i+1] ^ regs_q[i][31:0];
        end
      end
      LdNonce: begin
        blk[0]  = regs_q[RegNonceH][63:32];
        blk[1]  = regs_q[RegNonceH][31:0];
        blk[2]  = regs_q[RegNonceL][63:32];
        blk[3]  = regs_q[RegNonceL][31:0];
        blk[4]  = ctr_lo;
        blk[5]  = ctr_hi;
        blk[6]  = PadWord;
        blk[15] = InnerBits;
      end
      LdInner: begin
        for (int i = 0; i < 8; i++) blk[i] = inner_q[i];
        blk[8]  = PadWord;
        blk[15] = OuterBits;
      end
      default: ;
    endcase
  end

  // Rolling schedule: w_q[0] is always W[t].
  assign wt = w_q[0];
  assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wnew = w_q[0] + s0 + w_q[9] + s1;

  assign e  = v_q[4];
  assign a  = v_q[0];
  assign t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
              ((e & v_q[5]) ^ (~e & v_q[6])) + round_k(t_q) + wt;
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
              ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));

  assign sts_o.last_round = cmd_i.round && (t_q == 6'd63);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q <= '0;
    end else if (cmd_i.start) begin
      t_q <= '0;
    end else if (cmd_i.round) begin
      t_q <= t_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 16; i++) w_q[i] <= blk[i];
      if (cmd_i.init) begin
        for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
      end
    end
    if (cmd_i.start) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end
    if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
    if (cmd_i.fold) begin
      for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
    end
    if (cmd_i.save_inner) begin
      for (int i = 0; i < 8; i++) inner_q[i] <= h_q[i];
    end
    if (cmd_i.save_ks) begin
      ks_q <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};
    end
  end

  // Byte 0 of the block sits in the top bits.
  assign ks_byte_o = ks_q[(8'd255 - {off_i, 3'b000}) -: 8];

endmodule

### rtl/hsk_ctrl.sv
// ----------------------------------------------------------------------------
// hsk_ctrl: sequencer for the keystream unit
// Handles the byte handshakes, counter and offset, and steps the datapath
// through the four compressions of one HMAC block.
// ----------------------------------------------------------------------------
module hsk_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             in_eom_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o,
  output logic [63:0]      ctr_o,
  output logic [4:0]       off_o,
  output hsk_pkg::dp_cmd_t cmd_o,
  input  hsk_pkg::dp_sts_t sts_i,
  input  logic [7:0]       ks_byte_i
);
  import hsk_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StLoad, StStart, StRound, StFold, StEmit
  } state_e;

  state_e     state_q;
  logic [1:0] pass_q;
  logic [63:0] ctr_q;
  logic [4:0]  off_q;
  logic [7:0]  byte_q;
  logic        eom_q;
  logic        ovalid_q;
  logic [7:0]  obyte_q;
  logic        olast_q;
  logic        accept, can_out, emit;

  assign can_out    = !ovalid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  // A beat is written to the output register in this cycle.
  assign emit       = (state_q == StEmit) && !(off_q == 5'd0 && pass_q == 2'd0) && can_out;

  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;
  assign ctr_o = ctr_q;
  assign off_o = off_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.sel = load_sel_e'(pass_q);
    unique case (state_q)
      StLoad:  begin
        cmd_o.load = 1'b1;
        cmd_o.init = (pass_q == LdKeyIpad) || (pass_q == LdKeyOpad);
      end
      StStart: cmd_o.start = 1'b1;
      StRound: cmd_o.round = 1'b1;
      StFold:  cmd_o.fold = 1'b1;
      default: ;
    endcase
    // The sum is folded in StFold; the copies take it in the next state.
    if (state_q == StLoad && pass_q == LdKeyOpad) cmd_o.save_inner = 1'b1;
    if (state_q == StEmit && off_q == 5'd0 && pass_q == 2'd0) cmd_o.save_ks = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      pass_q   <= '0;
      ctr_q    <= '0;
      off_q    <= '0;
      byte_q   <= '0;
      eom_q    <= 1'b0;
      ovalid_q <= 1'b0;
      obyte_q  <= '0;
      olast_q  <= 1'b0;
    end else begin
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            byte_q <= in_byte_i;
            eom_q  <= in_eom_i;
            pass_q <= '0;
            state_q <= (off_q == 5'd0) ? StLoad : StEmit;
          end
        end
        StLoad:  state_q <= StStart;
        StStart: state_q <= StRound;
        StRound: if (sts_i.last_round) state_q <= StFold;
        StFold: begin
          pass_q  <= pass_q + 2'd1;
          state_q <= (pass_q == 2'd3) ? StEmit : StLoad;
          if (pass_q == 2'd3) ctr_q <= ctr_q + 64'd1;
        end
        StEmit: begin
          // When a block was just made, wait until ks_q has captured it.
          if (off_q == 5'd0 && pass_q == 2'd0) begin
            pass_q <= 2'd1;
          end else if (can_out) begin
            obyte_q  <= byte_q ^ ks_byte_i;
            olast_q  <= eom_q;
            off_q    <= eom_q ? 5'd0 : off_q + 5'd1;
            if (eom_q) ctr_q <= '0;
            state_q  <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o))
    else $error("output beat changed while stalled");
  a_eom_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && out_last_o |-> off_o == 5'd0 && ctr_o == 64'd0)
    else $error("end of message did not clear counter and offset");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !in_ready_o)
    else $error("input ready while busy");
`endif

endmodule

### rtl/hmac_sha256_ctr_keystream_xor_unit.sv
// ----------------------------------------------------------------------------
// hmac_sha256_ctr_keystream_xor_unit: HMAC-SHA256 counter-mode XOR cipher
// Each byte is XORed with a keystream byte; keystream blocks are the HMAC of
// the nonce and a little-endian 64-bit block counter under a 256-bit key.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  tdata / fields                  tuser
//  s_axis   in         data_byte[7:0]                  -, end_of_message on tlast
//  m_axis   out        out_byte[7:0]                   -, last on tlast
//  cfg      in         cfg_index_i[2:0], cfg_data_i    -
//
// A byte that opens a new 32-byte block waits for the single SHA-256 round
// unit to do four 64-round compressions; the other bytes use the block
// already made. One byte is in flight at a time. A stalled output beat is
// held in the output register while the next byte is already being processed.
// Reset clears the counter, offset, key and nonce registers.
module hmac_sha256_ctr_keystream_xor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [hsk_pkg::RegIdxW-1:0] cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import hsk_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [63:0] ctr;
  logic [4:0]  off;
  logic [7:0]  ks_byte;

  // Register writes are always taken; user must issue them only while idle.
  assign cfg_ready_o = 1'b1;

  hsk_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_eom_i    (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .ctr_o       (ctr),
    .off_o       (off),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .ks_byte_i   (ks_byte)
  );

  hsk_datapath u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_idx_i  (cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .ctr_i      (ctr),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .off_i      (off),
    .ks_byte_o  (ks_byte)
  );

endmodule
